FILE: sv/pfde_pkg.sv
// Shared types and constants for the page framebuffer draw engine.
`default_nettype none
package pfde_pkg;
  localparam int DisplayWidth = 128;
  localparam int DisplayPages = 4;
  localparam int DisplayRows  = DisplayPages * 8;
  localparam int MemDepth     = DisplayWidth * DisplayPages;
  localparam int AddrW        = $clog2(MemDepth);
  localparam int PageW        = (DisplayPages > 1) ? $clog2(DisplayPages) : 1;

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [2:0] {
    ACT_FILL   = 3'd0,
    ACT_POINT  = 3'd1,
    ACT_RECT   = 3'd2,
    ACT_DIAG   = 3'd3,
    ACT_GSTART = 3'd4,
    ACT_GBYTE  = 3'd5,
    ACT_READ   = 3'd6,
    ACT_NONE   = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL, ST_RD, ST_WR, ST_NEXT, ST_RDOUT, ST_RDWAIT, ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the request
    logic fill_wr;    // write fill byte at sweep address, advance sweep
    logic fill_init;  // start sweep with the given byte
    logic mem_rd;     // read the byte at the current pixel
    logic mem_wr;     // write back the modified byte
    logic step;       // advance the walk to the next pixel
    logic rd_out;     // read the readout address
    logic out_load;   // register the readout byte
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fill_last;
    logic walk_done;  // no pixel left to draw
  } sts_t;

  // Address of a pixel byte.
  function automatic addr_t pix_addr(input logic [7:0] col, input logic [7:0] row);
    logic [PageW-1:0] page;
    page = PageW'((DisplayPages - 1) - int'(row >> 3));
    return addr_t'(int'(col) * DisplayPages + int'(page));
  endfunction
endpackage
`default_nettype wire

FILE: sv/pfde_ctrl.sv
// Controller state machine for the page framebuffer draw engine.
`default_nettype none
module pfde_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_action,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire pfde_pkg::sts_t  sts,
  output pfde_pkg::cmd_t       cmd
);
  import pfde_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (action_t'(in_action))
            ACT_FILL:                    state_nxt = ST_FILL;
            ACT_POINT, ACT_RECT,
            ACT_DIAG, ACT_GBYTE:         state_nxt = ST_NEXT;
            ACT_READ:                    state_nxt = ST_RDOUT;
            default:                     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL:   if (sts.fill_last) state_nxt = ST_IDLE;
      ST_NEXT:   state_nxt = sts.walk_done ? ST_IDLE : ST_RD;
      ST_RD:     state_nxt = ST_WR;
      ST_WR:     state_nxt = ST_NEXT;
      ST_RDOUT:  state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = acc;
        cmd.fill_init  = acc && (action_t'(in_action) == ACT_FILL);
      end
      ST_FILL:   cmd.fill_wr = 1'b1;
      ST_RD:     cmd.mem_rd = 1'b1;
      ST_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.step   = 1'b1;
      end
      ST_RDOUT:  cmd.rd_out = 1'b1;
      ST_RDWAIT: cmd.out_load = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_FILL;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

FILE: sv/pfde_dp.sv
// Datapath of the draw engine: display memory, pixel walker and glyph cursor.
`default_nettype none
module pfde_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     in_action,
  input  wire logic [7:0]     in_x,
  input  wire logic [7:0]     in_y,
  input  wire logic [7:0]     in_x_end,
  input  wire logic [7:0]     in_y_end,
  input  wire logic [7:0]     in_value,
  input  wire logic [5:0]     in_glyph_width,
  input  wire logic           in_bit_order,
  input  wire pfde_pkg::cmd_t cmd,
  output pfde_pkg::sts_t      sts,
  output logic [7:0]          out_pixel_byte
);
  import pfde_pkg::*;

  logic [7:0] mem [MemDepth];
  logic [7:0] rdata_r;
  logic [7:0] out_r;

  // Request registers.
  action_t    act_r;
  logic [7:0] col_r, row_r, x0_r, xe_r, ye_r, val_r;
  logic [7:0] x0_row_r; // start row of the rectangle sweep
  logic [3:0] bit_r;    // glyph bit index, 8 means byte finished
  logic       first_r;  // first pixel of a walk not yet checked
  logic       pix_ink;  // ink of the current pixel

  // Glyph state.
  logic [7:0] cur_x_r, cur_y_r, org_x_r;
  logic [5:0] span_r;
  logic       inkm_r, lsb_r;

  // Fill sweep.
  addr_t      faddr_r;
  logic [7:0] fbyte_r;

  logic       in_range;
  addr_t      paddr;
  addr_t      raddr;
  logic       rd_in_range;
  logic [7:0] mask;
  logic [2:0] gsel;
  logic       gbit;
  logic [7:0] gx_inc;

  assign in_range    = (int'(col_r) < DisplayWidth) && (int'(row_r) < DisplayRows);
  assign paddr       = pix_addr(col_r, row_r);
  assign raddr       = addr_t'(int'(col_r) * DisplayPages + int'(row_r[PageW-1:0]));
  assign rd_in_range = (int'(col_r) < DisplayWidth) && (int'(row_r) < DisplayPages);
  assign mask        = 8'h80 >> row_r[2:0];
  assign gsel        = lsb_r ? bit_r[2:0] : 3'(7 - int'(bit_r[2:0]));
  assign gbit        = val_r[gsel];
  assign gx_inc      = cur_x_r + 8'd1;

  // Walk completion for each drawing action, and end of the fill sweep.
  always_comb begin
    sts = '0;
    case (act_r)
      ACT_POINT: sts.walk_done = !first_r;
      ACT_RECT:  sts.walk_done = (x0_r > xe_r) || (row_r > ye_r) ||
                                 (col_r > xe_r);
      ACT_DIAG:  sts.walk_done = (row_r > ye_r) || (!first_r && row_r == 8'd0);
      ACT_GBYTE: sts.walk_done = bit_r[3];
      default:   sts.walk_done = 1'b1;
    endcase
    sts.fill_last = (int'(faddr_r) == MemDepth - 1);
  end

  // Current pixel ink.
  always_comb begin
    pix_ink = val_r[0];
    if (act_r == ACT_GBYTE) pix_ink = gbit ? inkm_r : !inkm_r;
  end

  // Request capture and pixel walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action_t'(in_action);
      col_r   <= in_x;
      row_r   <= in_y;
      x0_r    <= in_x;
      xe_r    <= in_x_end;
      ye_r    <= in_y_end;
      val_r   <= in_value;
      bit_r   <= 4'd0;
      first_r <= 1'b1;
      if (action_t'(in_action) == ACT_GBYTE) begin
        col_r <= cur_x_r;
        row_r <= cur_y_r;
      end
    end else if (cmd.step) begin
      first_r <= 1'b0;
      case (act_r)
        ACT_RECT: begin
          if (row_r == ye_r) begin
            row_r <= x0_row_r;
            col_r <= col_r + 8'd1;
            if (col_r == 8'hFF) xe_r <= 8'd0;
            if (col_r == 8'hFF) x0_r <= 8'd1;
          end else begin
            row_r <= row_r + 8'd1;
          end
        end
        ACT_DIAG: begin
          row_r <= row_r + 8'd1;
          col_r <= col_r + 8'd1;
          if (row_r == 8'hFF) ye_r <= 8'd0;
        end
        ACT_GBYTE: begin
          if (gx_inc - org_x_r == {2'b00, span_r}) begin
            row_r <= cur_y_r + 8'd1;
            col_r <= org_x_r;
            bit_r <= 4'd8;
          end else begin
            col_r <= gx_inc;
            bit_r <= bit_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Start row of the rectangle sweep.
  always_ff @(posedge clk) begin
    if (cmd.load) x0_row_r <= in_y;
  end

  // Glyph cursor and modes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= 8'd0;
      cur_y_r <= 8'd0;
      org_x_r <= 8'd0;
      span_r  <= 6'd8;
      inkm_r  <= 1'b1;
      lsb_r   <= 1'b0;
    end else if (cmd.load && action_t'(in_action) == ACT_GSTART) begin
      cur_x_r <= in_x;
      cur_y_r <= in_y;
      org_x_r <= in_x;
      span_r  <= in_glyph_width;
      inkm_r  <= in_value[0];
      lsb_r   <= in_bit_order;
    end else if (cmd.step && act_r == ACT_GBYTE) begin
      if (gx_inc - org_x_r == {2'b00, span_r}) begin
        cur_x_r <= org_x_r;
        cur_y_r <= cur_y_r + 8'd1;
      end else begin
        cur_x_r <= gx_inc;
      end
    end
  end

  // Fill sweep; reset runs it with zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faddr_r <= '0;
      fbyte_r <= 8'd0;
    end else if (cmd.fill_init) begin
      faddr_r <= '0;
      fbyte_r <= in_value;
    end else if (cmd.fill_wr) begin
      faddr_r <= faddr_r + addr_t'(1);
    end
  end

  // Display memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.fill_wr) mem[faddr_r] <= fbyte_r;
    else if (cmd.mem_wr && in_range)
      mem[paddr] <= pix_ink ? (rdata_r | mask) : (rdata_r & ~mask);
    if (cmd.mem_rd) rdata_r <= mem[paddr];
    else if (cmd.rd_out) rdata_r <= mem[raddr];
  end

  // Readout register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= rd_in_range ? rdata_r : 8'd0;
  end
  assign out_pixel_byte = out_r;
endmodule
`default_nettype wire

FILE: sv/page_framebuffer_draw_engine.sv
// Top level of the page framebuffer draw engine.
// Point, rectangle, diagonal, glyph byte: each pixel is read, then written back.
// Glyph start and the unused code return straight to idle; fill writes one memory byte per cycle.
// Read byte: read, then registered, then out_valid; one request in flight at a time.
// After reset the memory is swept to zero, and no request is taken meanwhile.
`default_nettype none
module page_framebuffer_draw_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_x,
  input  wire logic [7:0] in_y,
  input  wire logic [7:0] in_x_end,
  input  wire logic [7:0] in_y_end,
  input  wire logic [7:0] in_value,
  input  wire logic [5:0] in_glyph_width,
  input  wire logic       in_bit_order,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_pixel_byte
);
  import pfde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfde_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action,
    .out_valid, .out_ready, .sts, .cmd
  );

  pfde_dp u_dp (
    .clk, .rst_n, .in_action, .in_x, .in_y, .in_x_end, .in_y_end,
    .in_value, .in_glyph_width, .in_bit_order, .cmd, .sts, .out_pixel_byte
  );
endmodule
`default_nettype wire

FILE: tb/tb_page_framebuffer_draw_engine.sv
// Self-checking testbench for the page framebuffer draw engine.
`default_nettype none
module tb_page_framebuffer_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import pfde_pkg::*;

  localparam int WatchdogLimit = 1000000;
  localparam int RandomRequests = 850;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_action;
  logic [7:0] in_x;
  logic [7:0] in_y;
  logic [7:0] in_x_end;
  logic [7:0] in_y_end;
  logic [7:0] in_value;
  logic [5:0] in_glyph_width;
  logic       in_bit_order;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_pixel_byte;

  page_framebuffer_draw_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_x(in_x), .in_y(in_y),
    .in_x_end(in_x_end), .in_y_end(in_y_end), .in_value(in_value),
    .in_glyph_width(in_glyph_width), .in_bit_order(in_bit_order),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_byte(out_pixel_byte)
  );

  typedef struct {
    action_t    act;
    logic [7:0] x, y, x_end, y_end, value;
    logic [5:0] gwidth;
    logic       order;
  } draw_req_t;

  // A directed row, with an optional typed-in readback byte.
  typedef struct {
    draw_req_t  req;
    bit         has_known;
    logic [7:0] known;
  } stim_row_t;

  // Shadow of the display and the glyph cursor.
  logic [7:0] shadow_mem [MemDepth];
  logic [7:0] cur_x, cur_y, org_x;
  logic [5:0] span;
  logic       ink, lsb_first;

  logic [7:0] readback_q [$];
  int         mismatches;
  bit         hold_off;
  int         idle_cycles;

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void shadow_plot(input int col, input int row, input logic pen);
    int pg;
    int idx;
    logic [7:0] mask;
    if (col >= DisplayWidth || row >= DisplayRows) return;
    pg = (DisplayPages - 1) - (row >> 3);
    idx = col * DisplayPages + pg;
    mask = 8'h80 >> (row & 7);
    if (pen) shadow_mem[idx] = shadow_mem[idx] | mask;
    else shadow_mem[idx] = shadow_mem[idx] & ~mask;
  endfunction

  // Applies one request to the shadow and queues the readback it causes.
  function automatic void predict_draw(input draw_req_t r);
    logic [7:0] col;
    logic       b;
    case (r.act)
      ACT_FILL: begin
        foreach (shadow_mem[i]) shadow_mem[i] = r.value;
      end
      ACT_POINT: shadow_plot(r.x, r.y, r.value[0]);
      ACT_RECT: begin
        for (int c = r.x; c <= r.x_end; c++)
          for (int w = r.y; w <= r.y_end; w++) shadow_plot(c, w, r.value[0]);
      end
      ACT_DIAG: begin
        col = r.x;
        for (int w = r.y; w <= r.y_end; w++) begin
          shadow_plot(col, w, r.value[0]);
          col = col + 8'd1;
        end
      end
      ACT_GSTART: begin
        cur_x = r.x;
        org_x = r.x;
        cur_y = r.y;
        span = r.gwidth;
        ink = r.value[0];
        lsb_first = r.order;
      end
      ACT_GBYTE: begin
        for (int k = 0; k < 8; k++) begin
          b = lsb_first ? r.value[k] : r.value[7-k];
          shadow_plot(cur_x, cur_y, b ? ink : ~ink);
          cur_x = cur_x + 8'd1;
          if (8'(cur_x - org_x) == {2'b00, span}) begin
            cur_x = org_x;
            cur_y = cur_y + 8'd1;
            break;
          end
        end
      end
      ACT_READ: begin
        if (r.x < DisplayWidth && r.y < DisplayPages)
          readback_q.push_back(shadow_mem[int'(r.x) * DisplayPages + int'(r.y)]);
        else
          readback_q.push_back(8'h00);
      end
      default: ;
    endcase
  endfunction

  function automatic draw_req_t mk(input action_t a, input int x, input int y,
                                   input int xe, input int ye, input int v,
                                   input int gw, input int o);
    draw_req_t r;
    r.act = a; r.x = 8'(x); r.y = 8'(y); r.x_end = 8'(xe); r.y_end = 8'(ye);
    r.value = 8'(v); r.gwidth = 6'(gw); r.order = 1'(o);
    return r;
  endfunction

  // Mostly on-screen coordinates, with some anywhere in the field.
  function automatic draw_req_t rand_req();
    draw_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, DisplayWidth - 1));
    r.y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, DisplayRows - 1));
    r.x_end = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(r.x + $urandom_range(0, 6));
    r.y_end = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(r.y + $urandom_range(0, 6));
    r.value = 8'($urandom);
    r.gwidth = 6'($urandom);
    r.order = 1'($urandom);
    if (sel < 1) r.act = ACT_FILL;
    else if (sel < 2) r.act = ACT_NONE;
    else if (sel < 20) r.act = ACT_POINT;
    else if (sel < 28) r.act = ACT_RECT;
    else if (sel < 34) r.act = ACT_DIAG;
    else if (sel < 40) r.act = ACT_GSTART;
    else if (sel < 60) r.act = ACT_GBYTE;
    else begin
      r.act = ACT_READ;
      if ($urandom_range(0, 7) != 0) begin
        r.x = 8'($urandom_range(0, DisplayWidth - 1));
        r.y = 8'($urandom_range(0, DisplayPages - 1));
      end
    end
    // Random widths up to 32 mostly, occasionally zero or beyond.
    if (r.act == ACT_GSTART && $urandom_range(0, 7) != 0)
      r.gwidth = 6'($urandom_range(1, 32));
    // Diagonals that are long run off screen; the caller keeps them bounded on most draws.
    return r;
  endfunction

  // Drops valid only when a gap follows, so valid gets one update per edge.
  task automatic send_request(input draw_req_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.act;
    in_x <= r.x;
    in_y <= r.y;
    in_x_end <= r.x_end;
    in_y_end <= r.y_end;
    in_value <= r.value;
    in_glyph_width <= r.gwidth;
    in_bit_order <= r.order;
    do @(posedge clk); while (!in_ready);
    predict_draw(r);
  endtask

  // Receiver side with random stalls.
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) continue;
      if (out_valid && out_ready) begin
        if (readback_q.size() == 0) report("unexpected readback", out_pixel_byte, 8'h00);
        else begin
          if (out_pixel_byte !== readback_q[0])
            report("pixel_byte", out_pixel_byte, readback_q[0]);
          void'(readback_q.pop_front());
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else begin
        gap = $urandom_range(0, 15);
        out_ready <= ($urandom_range(0, 3) == 0) ? 1'b1 : (gap < 6);
      end
    end
  end

  // Watchdog on cycles with no accepted request or taken readback, outside the receiver hold-off.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || hold_off)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired at %0t", $realtime);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t  rows [$];
    draw_req_t  r;
    int         n;
    mismatches = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_NONE;
    in_x = 8'h00; in_y = 8'h00; in_x_end = 8'h00; in_y_end = 8'h00;
    in_value = 8'h00; in_glyph_width = 6'd8; in_bit_order = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    cur_x = 0; cur_y = 0; org_x = 0; span = 6'd8; ink = 1'b1; lsb_first = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; typed-in bytes where they are obvious.
    rows.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 8, 0), 1'b1, 8'h00});
    rows.push_back('{mk(ACT_READ, 127, 3, 0, 0, 0, 8, 0), 1'b1, 8'h00});
    rows.push_back('{mk(ACT_POINT, 0, 0, 0, 0, 1, 8, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_READ, 0, 3, 0, 0, 0, 8, 0), 1'b1, 8'h80});
    rows.push_back('{mk(ACT_POINT, 127, 31, 0, 0, 8'hFF, 8, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_READ, 127, 0, 0, 0, 0, 8, 0), 1'b1, 8'h01});
    rows.push_back('{mk(ACT_POINT, 255, 255, 0, 0, 1, 8, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_READ, 255, 255, 0, 0, 0, 8, 0), 1'b1, 8'h00});
    rows.push_back('{mk(ACT_READ, 5, 4, 0, 0, 0, 8, 0), 1'b1, 8'h00});
    rows.push_back('{mk(ACT_NONE, 1, 1, 9, 9, 8'hFF, 63, 1), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GBYTE, 0, 0, 0, 0, 8'hA5, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_RECT, 2, 0, 5, 9, 1, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_RECT, 9, 9, 2, 2, 1, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_DIAG, 126, 20, 0, 24, 1, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_DIAG, 250, 0, 0, 12, 1, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GSTART, 10, 8, 0, 0, 0, 3, 1), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GBYTE, 0, 0, 0, 0, 8'h5A, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GSTART, 120, 30, 0, 0, 1, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GBYTE, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GSTART, 20, 16, 0, 0, 1, 32, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_GBYTE, 0, 0, 0, 0, 8'h81, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_READ, 20, 1, 0, 0, 0, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_FILL, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b0, 8'h00});
    rows.push_back('{mk(ACT_READ, 64, 2, 0, 0, 0, 0, 0), 1'b1, 8'hFF});
    rows.push_back('{mk(ACT_FILL, 0, 0, 0, 0, 8'h00, 0, 0), 1'b0, 8'h00});

    foreach (rows[i]) begin
      send_request(rows[i].req);
      // A typed-in byte must agree with the shadow it was queued from.
      if (rows[i].has_known && readback_q[$] !== rows[i].known)
        report("directed readback", readback_q[$], rows[i].known);
    end

    // Random part, with one long receiver stall in the middle.
    n = 0;
    while (n < RandomRequests) begin
      r = rand_req();
      if (r.act == ACT_DIAG && r.y_end > r.y + 40 && $urandom_range(0, 3) != 0)
        r.y_end = r.y + 8'($urandom_range(0, 40));
      if (n == RandomRequests / 2 && !hold_off) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      send_request(r);
      if (r.act != ACT_NONE) n++;
    end
    in_valid <= 1'b0;

    while (readback_q.size() != 0 || hold_off) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
